>>> sv/gps_pkg.sv
package gps_pkg;

  localparam int unsigned FracBits   = 24;
  localparam int unsigned UniWidth   = 24;
  localparam int unsigned SampleW    = 24;
  localparam int unsigned BatchW     = 16;
  localparam int unsigned SigmaW     = 23;
  localparam int unsigned CfgAddrW   = 2;
  localparam int unsigned CfgDataW   = 24;

  // ln(2) as a Q0.64 constant, split into two 32-bit halves.
  localparam logic [31:0] Ln2Hi = 32'hB17217F7;
  localparam logic [31:0] Ln2Lo = 32'hD1CF79AB;

  localparam logic signed [28:0] SampleMax = 29'sd8388607;
  localparam logic signed [28:0] SampleMin = -29'sd8388608;

  localparam logic [CfgAddrW-1:0] RegBatchCount = 2'd0;
  localparam logic [CfgAddrW-1:0] RegMeanOffset = 2'd1;
  localparam logic [CfgAddrW-1:0] RegScaleSigma = 2'd2;

endpackage

>>> sv/gps_div.sv
module gps_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [48:0] num_i,
  input  logic [47:0] den_i,
  output logic        busy_o,
  output logic [24:0] quo_o
);

  logic [49:0] rem_q, rem_d;
  logic [24:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [49:0] rem_sh;
  logic        ge;

  // The first step compares without a shift, so that the integer bit of the quotient comes first.
  assign rem_sh = (cnt_q == 5'd0) ? rem_q : {rem_q[48:0], 1'b0};
  assign ge     = rem_sh >= {2'b00, den_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {2'b00, den_i}) : rem_sh;
      quo_d = {quo_q[23:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd24) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

>>> sv/gps_sqrt.sv
module gps_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] rad_i,
  output logic        busy_o,
  output logic [27:0] root_o
);

  logic [55:0] n_q, n_d;
  logic [30:0] rem_q, rem_d;
  logic [27:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [30:0] rem_sh;
  logic [29:0] trial;
  logic        ge;

  // Restoring square root, two radicand bits per step.
  assign rem_sh = {rem_q[28:0], n_q[55:54]};
  assign trial  = {root_q, 2'b01};
  assign ge     = rem_sh >= {1'b0, trial};

  always_comb begin
    n_d    = n_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      n_d    = {rad_i, 24'd0};
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d    = {n_q[53:0], 2'b00};
      rem_d  = ge ? (rem_sh - {1'b0, trial}) : rem_sh;
      root_d = {root_q[26:0], ge};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd27) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

>>> sv/gaussian_polar_sampler_unit.sv
// An accepted request runs through squaring, normalizing (one shift per leading zero of s)
// and the logarithm, then one division, multiply and square root per sample.
// A new request is taken only in the idle state; a rejected pair returns there from the check.
// The 25-step divider and the 28-step square root set the per-sample time.
// Reset (rst_ni low, asynchronous) clears the sequencer, output valid and sample counter,
// and restores batch_count 1, mean_offset 0 and scale_sigma 1.0.
module gaussian_polar_sampler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // uniform_first [23:0], uniform_second [47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // sample_value [23:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [23:0] cfg_data_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSq1  = 4'd1;
  localparam logic [3:0] StSq2  = 4'd2;
  localparam logic [3:0] StChk  = 4'd3;
  localparam logic [3:0] StNorm = 4'd4;
  localparam logic [3:0] StLog  = 4'd5;
  localparam logic [3:0] StLnLo = 4'd6;
  localparam logic [3:0] StLnHi = 4'd7;
  localparam logic [3:0] StDivG = 4'd8;
  localparam logic [3:0] StDivW = 4'd9;
  localparam logic [3:0] StRMul = 4'd10;
  localparam logic [3:0] StSqG  = 4'd11;
  localparam logic [3:0] StSqW  = 4'd12;
  localparam logic [3:0] StSMul = 4'd13;
  localparam logic [3:0] StEmit = 4'd14;

  logic [3:0]  state_q, state_d;
  logic [15:0] batch_q;
  logic signed [23:0] mean_q;
  logic [22:0] sigma_q;
  logic [15:0] cnt_q, cnt_d;

  logic signed [25:0] v1_q, v2_q;
  logic [48:0] sq1_q, sq2_q;
  logic [49:0] s_q;
  logic [47:0] norm_q;
  logic [5:0]  k_q;
  logic [24:0] m_q;
  logic [23:0] frac_q;
  logic [4:0]  it_q;
  logic [29:0] plo_q;
  logic [30:0] l_q;
  logic [31:0] pr_q;
  logic [26:0] mag_q;
  logic        sel_q, two_q, last1_q, last2_q;
  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic        out_last_q;

  logic [24:0] av1, av2;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [29:0] lg;
  logic [62:0] lsum;
  logic [25:0] msq;
  logic        accept, out_free;
  logic [15:0] bc;
  logic [16:0] cnt1, cnt2;
  logic signed [28:0] smag, val;
  logic [23:0] sat;
  logic        div_start, div_busy, sq_start, sq_busy;
  logic [24:0] quo;
  logic [27:0] root;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign av1 = v1_q[25] ? 25'(-v1_q) : v1_q[24:0];
  assign av2 = v2_q[25] ? 25'(-v2_q) : v2_q[24:0];

  // -log2(s) = (k + 1) - log2(m), with k leading zeros below bit 47.
  assign lg   = {6'(k_q + 6'd1), 24'd0} - {6'd0, frac_q};
  assign lsum = {1'b0, prod[61:0]} + {33'd0, plo_q};
  assign msq  = prod[49:24];

  // The one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StSq1: begin
        mul_a = {7'd0, av1};
        mul_b = {7'd0, av1};
      end
      StSq2: begin
        mul_a = {7'd0, av2};
        mul_b = {7'd0, av2};
      end
      StLog: begin
        mul_a = {7'd0, m_q};
        mul_b = {7'd0, m_q};
      end
      StLnLo: begin
        mul_a = {2'd0, lg};
        mul_b = gps_pkg::Ln2Lo;
      end
      StLnHi: begin
        mul_a = {2'd0, lg};
        mul_b = gps_pkg::Ln2Hi;
      end
      StRMul: begin
        mul_a = {7'd0, quo};
        mul_b = {1'b0, l_q};
      end
      StSMul: begin
        mul_a = {9'd0, sigma_q};
        mul_b = {4'd0, root};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign bc   = (batch_q == 16'd0) ? 16'd1 : batch_q;
  assign cnt1 = {1'b0, cnt_q} + 17'd1;
  assign cnt2 = {1'b0, cnt_q} + 17'd2;

  assign smag = $signed({2'b00, mag_q});
  assign val  = ((sel_q ? v2_q[25] : v1_q[25]) ? -smag : smag)
              + {{5{mean_q[23]}}, mean_q};
  assign sat  = (val > gps_pkg::SampleMax) ? 24'h7FFFFF :
                (val < gps_pkg::SampleMin) ? 24'h800000 : val[23:0];

  assign div_start = (state_q == StDivG);
  assign sq_start  = (state_q == StSqG);

  gps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sel_q ? sq2_q : sq1_q),
    .den_i   (s_q[47:0]),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  gps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (pr_q),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: if (accept) state_d = StSq1;
      StSq1:  state_d = StSq2;
      StSq2:  state_d = StChk;
      StChk: begin
        if (s_q[49:48] != 2'b00 || s_q == 50'd0) begin
          state_d = StIdle;
        end else begin
          state_d = StNorm;
          if (cnt1 >= {1'b0, bc}) begin
            cnt_d = '0;
          end else if (cnt2 == {1'b0, bc}) begin
            cnt_d = '0;
          end else begin
            cnt_d = cnt2[15:0];
          end
        end
      end
      StNorm: if (norm_q[47]) state_d = StLog;
      StLog:  if (it_q == 5'd23) state_d = StLnLo;
      StLnLo: state_d = StLnHi;
      StLnHi: state_d = StDivG;
      StDivG: state_d = StDivW;
      StDivW: if (!div_busy) state_d = StRMul;
      StRMul: state_d = StSqG;
      StSqG:  state_d = StSqW;
      StSqW:  if (!sq_busy) state_d = StSMul;
      StSMul: state_d = StEmit;
      StEmit: begin
        if (out_free) begin
          state_d = (!sel_q && two_q) ? StDivG : StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      batch_q     <= 16'd1;
      mean_q      <= '0;
      sigma_q     <= 23'd65536;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          gps_pkg::RegBatchCount: batch_q <= cfg_data_i[15:0];
          gps_pkg::RegMeanOffset: mean_q  <= $signed(cfg_data_i);
          gps_pkg::RegScaleSigma: sigma_q <= cfg_data_i[22:0];
          default: ;
        endcase
      end
      if (state_q == StEmit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        v1_q  <= $signed({1'b0, s_axis_tdata[23:0], 1'b0}) - 26'sh1000000;
        v2_q  <= $signed({1'b0, s_axis_tdata[47:24], 1'b0}) - 26'sh1000000;
        sel_q <= 1'b0;
      end
      StSq1: sq1_q <= prod[48:0];
      StSq2: begin
        sq2_q <= prod[48:0];
        s_q   <= {1'b0, sq1_q} + {1'b0, prod[48:0]};
      end
      StChk: begin
        norm_q  <= s_q[47:0];
        k_q     <= '0;
        two_q   <= !(cnt1 >= {1'b0, bc});
        last1_q <= cnt1 >= {1'b0, bc};
        last2_q <= cnt2 == {1'b0, bc};
      end
      StNorm: begin
        if (norm_q[47]) begin
          m_q    <= norm_q[47:23];
          frac_q <= '0;
          it_q   <= '0;
        end else begin
          norm_q <= {norm_q[46:0], 1'b0};
          k_q    <= k_q + 6'd1;
        end
      end
      StLog: begin
        m_q    <= msq[25] ? msq[25:1] : msq[24:0];
        frac_q <= {frac_q[22:0], msq[25]};
        it_q   <= it_q + 5'd1;
      end
      StLnLo: plo_q <= prod[61:32];
      StLnHi: l_q <= lsum[61:31];
      StRMul: pr_q <= prod[55:24];
      StSMul: mag_q <= prod[50:24];
      StEmit: begin
        if (out_free) begin
          out_data_q <= sat;
          out_last_q <= sel_q ? last2_q : last1_q;
          sel_q      <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> sv/gps_checker.sv
module gps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // The unit works on one request at a time.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while the previous one is in work");

  // A new sample needs the squares first, so none appears right after a request.
  a_no_instant_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("sample appeared too early after a request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("sample dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled sample changed");

endmodule

bind gaussian_polar_sampler_unit gps_checker u_gps_checker (.*);
